// ===== hdl/eigen_sphericality_descriptor_assert.svh =====
// Assertion macros for the sphericality descriptor
`ifndef EIGEN_SPHERICALITY_DESCRIPTOR_ASSERT_SVH
`define EIGEN_SPHERICALITY_DESCRIPTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Check an implication on every rising clock edge outside reset
`define ESD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent follows an antecedent after a fixed delay
`define ESD_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`else

`define ESD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ESD_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg)

`endif

`endif

// ===== hdl/esd_pkg.sv =====
`timescale 1ns / 1ps

package esd_pkg;

   // Input value width and fraction bits of the results
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // Result field widths
   localparam int SPH_W    = 18;
   localparam int UNS_W    = 17;
   localparam int STATUS_W = 2;

   // Configuration port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMIT_UNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMIT_STR = 1'd1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDEFINED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd2;

   // Iteration counts of the cell chain
   localparam int DIV_STEPS  = FRAC_BITS + 1;
   localparam int FRAC_STEPS = 2 * FRAC_BITS + 1;
   localparam int SQRT_STEPS = FRAC_BITS + 1;
   localparam int CELL_COUNT = FRAC_STEPS + SQRT_STEPS;
   localparam int CELL_IDX_W = $clog2(CELL_COUNT);

   // Pipeline depth: front stages, cells, product stage, output stage
   localparam int FRONT_STAGES = 6;
   localparam int LATENCY      = FRONT_STAGES + CELL_COUNT + 2;

   // Work carried from cell to cell
   typedef struct packed {
      logic                       vld;
      logic [STATUS_W-1:0]        status;
      logic [VALUE_WIDTH-2:0]     div;
      logic [VALUE_WIDTH-1:0]     un_rem;
      logic [FRAC_BITS:0]         un_quo;
      logic [VALUE_WIDTH-1:0]     q1_rem;
      logic [FRAC_BITS:0]         q1_quo;
      logic [2*VALUE_WIDTH-1:0]   den;
      logic [2*VALUE_WIDTH-1:0]   fr_rem;
      logic [2*FRAC_BITS:0]       fr_quo;
      logic [2*FRAC_BITS+1:0]     sq_x;
      logic [2*FRAC_BITS+1:0]     sq_res;
   } esd_cell_type;

endpackage

// ===== hdl/eigen_sphericality_descriptor.sv =====
`timescale 1ns / 1ps

// Sphericality descriptor of one point from its three unsorted eigenvalues.
// A triple is taken in every cycle (busy stays low) and its result appears
// on the rsp_ ports for one cycle, marked by rsp_strobe, once it has passed
// the pipeline; results come in input order and the receiver must take
// each one as it appears. The pipeline is six front stages (sort,
// classify, square, sum), a chain of 50 cells running the two 17-step
// ratio dividers beside the 33-step fraction divider, then the 17-step
// root, one step per cell, and two stages for the product and difference.
// Configuration writes complete at once (csr_ready stays high).

`include "eigen_sphericality_descriptor_assert.svh"

module eigen_sphericality_descriptor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [esd_pkg::VALUE_WIDTH-1:0] req_eig_first,
   input  logic signed [esd_pkg::VALUE_WIDTH-1:0] req_eig_second,
   input  logic signed [esd_pkg::VALUE_WIDTH-1:0] req_eig_third,
   output logic                                   rsp_strobe,
   output logic signed [esd_pkg::SPH_W-1:0]       rsp_sphericality,
   output logic [esd_pkg::UNS_W-1:0]              rsp_unstructureness,
   output logic [esd_pkg::UNS_W-1:0]              rsp_structureness,
   output logic [esd_pkg::STATUS_W-1:0]           rsp_status,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [esd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic                                   csr_wdata
);

   localparam int F = esd_pkg::FRAC_BITS;

   esd_pkg::esd_cell_type chain [esd_pkg::CELL_COUNT+1];
   esd_pkg::esd_cell_type last;

   logic emit_uns_ff, emit_uns_in, emit_str_ff, emit_str_in;
   logic                         m_vld_ff;
   logic [esd_pkg::STATUS_W-1:0] m_status_ff;
   logic [F:0]                   m_un_ff;
   logic [2*F+1:0]               m_prod_ff;
   logic [F:0]                   st_val;
   logic signed [F+1:0]          sph_val;
   logic                         out_vld_ff;
   logic signed [esd_pkg::SPH_W-1:0] out_sph_ff, out_sph_in;
   logic [esd_pkg::UNS_W-1:0]    out_uns_ff, out_uns_in, out_str_ff, out_str_in;
   logic [esd_pkg::STATUS_W-1:0] out_status_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Decode configuration writes
   always_comb begin
      emit_uns_in = emit_uns_ff;
      emit_str_in = emit_str_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            esd_pkg::CSR_EMIT_UNS: emit_uns_in = csr_wdata;
            esd_pkg::CSR_EMIT_STR: emit_str_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_uns_ff <= 1'b0;
         emit_str_ff <= 1'b0;
      end else begin
         emit_uns_ff <= emit_uns_in;
         emit_str_ff <= emit_str_in;
      end
   end

   // Sort, classify and square
   esd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (start && !busy),
      .eig_first  (req_eig_first),
      .eig_second (req_eig_second),
      .eig_third  (req_eig_third),
      .cell_out   (chain[0])
   );

   // Chain of step cells
   for (genvar i = 0; i < esd_pkg::CELL_COUNT; i++) begin : g_cell
      esd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (esd_pkg::CELL_IDX_W'(i)),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign last = chain[esd_pkg::CELL_COUNT];

   // Multiply the ratio by the root
   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= last.vld;
      end
   end

   always_ff @(posedge clock) begin
      m_status_ff <= last.status;
      m_un_ff     <= last.un_quo;
      m_prod_ff   <= (2*F+2)'(last.q1_quo) * (2*F+2)'(last.sq_res[F:0]);
   end

   // Form the difference and apply status and enables
   always_comb begin
      st_val  = m_prod_ff[2*F:F];
      sph_val = $signed({1'b0, m_un_ff}) - $signed({1'b0, st_val});
      if (m_status_ff == esd_pkg::STATUS_OK) begin
         out_sph_in = esd_pkg::SPH_W'(sph_val);
         out_uns_in = emit_uns_ff ? esd_pkg::UNS_W'(m_un_ff) : '0;
         out_str_in = emit_str_ff ? esd_pkg::UNS_W'(st_val) : '0;
      end else begin
         out_sph_in = '0;
         out_uns_in = '0;
         out_str_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_sph_ff    <= out_sph_in;
      out_uns_ff    <= out_uns_in;
      out_str_ff    <= out_str_in;
      out_status_ff <= m_status_ff;
   end

   assign rsp_strobe          = out_vld_ff;
   assign rsp_sphericality    = out_sph_ff;
   assign rsp_unstructureness = out_uns_ff;
   assign rsp_structureness   = out_str_ff;
   assign rsp_status          = out_status_ff;

   // Every start transfer yields a result after the fixed latency
   `ESD_ASSERT_DELAY(a_latency, clock, reset, start && !busy, esd_pkg::LATENCY, rsp_strobe, "result missing after start")

   // A point without a valid status carries zero values
   `ESD_ASSERT_IMPL(a_zero_on_status, clock, reset, rsp_strobe && (rsp_status != esd_pkg::STATUS_OK), (rsp_sphericality == '0) && (rsp_unstructureness == '0) && (rsp_structureness == '0), "nonzero values with bad status")

   // Disabled outputs stay zero
   `ESD_ASSERT_IMPL(a_emit_gate, clock, reset, rsp_strobe && !emit_uns_ff && !emit_str_ff, (rsp_unstructureness == '0) && (rsp_structureness == '0), "disabled output driven")

endmodule

// ===== hdl/esd_front.sv =====
`timescale 1ns / 1ps

module esd_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_vld,
   input  logic signed [esd_pkg::VALUE_WIDTH-1:0] eig_first,
   input  logic signed [esd_pkg::VALUE_WIDTH-1:0] eig_second,
   input  logic signed [esd_pkg::VALUE_WIDTH-1:0] eig_third,
   output esd_pkg::esd_cell_type                  cell_out
);

   localparam int VW = esd_pkg::VALUE_WIDTH;

   logic                 vld_ff [esd_pkg::FRONT_STAGES-1];
   logic signed [VW-1:0] a_ff, b_ff, c_ff;
   logic signed [VW-1:0] lo_ff, hi_ff, c2_ff;
   logic signed [VW-1:0] s0_ff, s1_ff, s2_ff;
   logic signed [VW-1:0] mid_in, s2_in, s0_in, s1_in;
   logic [esd_pkg::STATUS_W-1:0] st_d_ff, st_e_ff, status_in;
   logic [VW-2:0] u0_d_ff, u1_d_ff, u2_d_ff, diff_d_ff;
   logic [VW-2:0] u0_e_ff, u1_e_ff, u2_e_ff;
   logic [2*VW-3:0] sq0_e_ff, sq1_e_ff, sqd_e_ff;
   logic signed [VW-1:0] diff_in;
   esd_pkg::esd_cell_type cell_ff, cell_in;

   // Finish the sort: place the largest, then split the rest
   always_comb begin
      s2_in  = (hi_ff > c2_ff) ? hi_ff : c2_ff;
      mid_in = (hi_ff > c2_ff) ? c2_ff : hi_ff;
      s0_in  = (lo_ff > mid_in) ? mid_in : lo_ff;
      s1_in  = (lo_ff > mid_in) ? lo_ff : mid_in;
   end

   // Classify the sorted triple
   always_comb begin
      diff_in = s1_ff - s0_ff;
      if ((s2_ff <= 0) || (s0_ff < 0)) begin
         status_in = esd_pkg::STATUS_UNDEFINED;
      end else if (s1_ff == 0) begin
         status_in = esd_pkg::STATUS_DEGENERATE;
      end else begin
         status_in = esd_pkg::STATUS_OK;
      end
   end

   // Load the first cell: remainders start at the dividends
   always_comb begin
      cell_in        = '0;
      cell_in.vld    = vld_ff[esd_pkg::FRONT_STAGES-2];
      cell_in.status = st_e_ff;
      cell_in.div    = u2_e_ff;
      cell_in.un_rem = VW'(u0_e_ff);
      cell_in.q1_rem = VW'(u1_e_ff);
      cell_in.den    = (2*VW)'(sq0_e_ff) + (2*VW)'(sq1_e_ff);
      cell_in.fr_rem = (2*VW)'(sqd_e_ff);
   end

   // Advance the valid marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < esd_pkg::FRONT_STAGES-1; i++) vld_ff[i] <= 1'b0;
         cell_ff <= '0;
      end else begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < esd_pkg::FRONT_STAGES-1; i++) vld_ff[i] <= vld_ff[i-1];
         cell_ff <= cell_in;
      end
   end

   // Hold payload through sort, classify and square stages
   always_ff @(posedge clock) begin
      a_ff      <= eig_first;
      b_ff      <= eig_second;
      c_ff      <= eig_third;
      lo_ff     <= (a_ff > b_ff) ? b_ff : a_ff;
      hi_ff     <= (a_ff > b_ff) ? a_ff : b_ff;
      c2_ff     <= c_ff;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      st_d_ff   <= status_in;
      u0_d_ff   <= s0_ff[VW-2:0];
      u1_d_ff   <= s1_ff[VW-2:0];
      u2_d_ff   <= s2_ff[VW-2:0];
      diff_d_ff <= diff_in[VW-2:0];
      st_e_ff   <= st_d_ff;
      u0_e_ff   <= u0_d_ff;
      u1_e_ff   <= u1_d_ff;
      u2_e_ff   <= u2_d_ff;
      sq0_e_ff  <= (2*VW-2)'(u0_d_ff) * (2*VW-2)'(u0_d_ff);
      sq1_e_ff  <= (2*VW-2)'(u1_d_ff) * (2*VW-2)'(u1_d_ff);
      sqd_e_ff  <= (2*VW-2)'(diff_d_ff) * (2*VW-2)'(diff_d_ff);
   end

   assign cell_out = cell_ff;

endmodule

// ===== hdl/esd_cell.sv =====
`timescale 1ns / 1ps

module esd_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [esd_pkg::CELL_IDX_W-1:0]      cell_idx,
   input  esd_pkg::esd_cell_type               cell_in,
   output esd_pkg::esd_cell_type               cell_out
);

   localparam int VW = esd_pkg::VALUE_WIDTH;
   localparam int SW = 2 * esd_pkg::FRAC_BITS + 2;

   esd_pkg::esd_cell_type cell_ff, next_in;
   logic [VW-1:0]         un_rr, q1_rr;
   logic [2*VW-1:0]       fr_rr;
   logic [SW-1:0]         x_cur, res_cur, bit_val, trial;
   logic [esd_pkg::CELL_IDX_W-1:0] steps_left;
   logic                  first;

   // One restoring step of each active divider, or one step of the root
   always_comb begin
      next_in    = cell_in;
      first      = (cell_idx == '0);
      un_rr      = first ? cell_in.un_rem : {cell_in.un_rem[VW-2:0], 1'b0};
      q1_rr      = first ? cell_in.q1_rem : {cell_in.q1_rem[VW-2:0], 1'b0};
      fr_rr      = first ? cell_in.fr_rem : {cell_in.fr_rem[2*VW-2:0], 1'b0};
      steps_left = esd_pkg::CELL_IDX_W'(esd_pkg::CELL_COUNT - 1) - cell_idx;
      bit_val    = SW'(1) << {steps_left, 1'b0};
      if (cell_idx == esd_pkg::CELL_IDX_W'(esd_pkg::FRAC_STEPS)) begin
         x_cur   = SW'(cell_in.fr_quo);
         res_cur = '0;
      end else begin
         x_cur   = cell_in.sq_x;
         res_cur = cell_in.sq_res;
      end
      trial = res_cur + bit_val;

      if (cell_idx < esd_pkg::CELL_IDX_W'(esd_pkg::DIV_STEPS)) begin
         if (un_rr >= VW'(cell_in.div)) begin
            next_in.un_rem = un_rr - VW'(cell_in.div);
            next_in.un_quo = {cell_in.un_quo[esd_pkg::FRAC_BITS-1:0], 1'b1};
         end else begin
            next_in.un_rem = un_rr;
            next_in.un_quo = {cell_in.un_quo[esd_pkg::FRAC_BITS-1:0], 1'b0};
         end
         if (q1_rr >= VW'(cell_in.div)) begin
            next_in.q1_rem = q1_rr - VW'(cell_in.div);
            next_in.q1_quo = {cell_in.q1_quo[esd_pkg::FRAC_BITS-1:0], 1'b1};
         end else begin
            next_in.q1_rem = q1_rr;
            next_in.q1_quo = {cell_in.q1_quo[esd_pkg::FRAC_BITS-1:0], 1'b0};
         end
      end

      if (cell_idx < esd_pkg::CELL_IDX_W'(esd_pkg::FRAC_STEPS)) begin
         if (fr_rr >= cell_in.den) begin
            next_in.fr_rem = fr_rr - cell_in.den;
            next_in.fr_quo = {cell_in.fr_quo[2*esd_pkg::FRAC_BITS-1:0], 1'b1};
         end else begin
            next_in.fr_rem = fr_rr;
            next_in.fr_quo = {cell_in.fr_quo[2*esd_pkg::FRAC_BITS-1:0], 1'b0};
         end
      end else begin
         if (x_cur >= trial) begin
            next_in.sq_x   = x_cur - trial;
            next_in.sq_res = (res_cur >> 1) + bit_val;
         end else begin
            next_in.sq_x   = x_cur;
            next_in.sq_res = res_cur >> 1;
         end
      end
   end

   // Hand the work to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= next_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // Expected result of one eigenvalue triple
   typedef struct packed {
      logic signed [esd_pkg::SPH_W-1:0] sph;
      logic [esd_pkg::UNS_W-1:0]        uns;
      logic [esd_pkg::UNS_W-1:0]        str;
      logic [esd_pkg::STATUS_W-1:0]     status;
   } descriptor_type;

   class descriptor_scoreboard;
      descriptor_type pending[$];
      bit             emit_uns;
      bit             emit_str;
      int             mismatches;

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned res;
         longint unsigned bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv >>= 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x   -= res + bitv;
               res  = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // floor(num * 2^(2F) / den), num <= den
      function longint unsigned ratio_2f(longint unsigned num, longint unsigned den);
         longint unsigned q;
         longint unsigned r;
         q = num / den;
         r = num % den;
         for (int i = 0; i < 2 * esd_pkg::FRAC_BITS; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= den) begin
               r -= den;
               q |= 1;
            end
         end
         return q;
      endfunction

      function void note_triple(logic signed [31:0] e0, logic signed [31:0] e1,
                                logic signed [31:0] e2);
         longint          a, b, c, t;
         longint unsigned s0, s1, s2, un, q1, q2, st;
         longint          diff;
         descriptor_type  d;
         a = e0; b = e1; c = e2;
         if (a > b) begin t = a; a = b; b = t; end
         if (b > c) begin t = b; b = c; c = t; end
         if (a > b) begin t = a; a = b; b = t; end
         d = '0;
         if (c <= 0 || a < 0) begin
            d.status = esd_pkg::STATUS_UNDEFINED;
         end else if (b == 0) begin
            d.status = esd_pkg::STATUS_DEGENERATE;
         end else begin
            s0 = a; s1 = b; s2 = c;
            un = (s0 << esd_pkg::FRAC_BITS) / s2;
            q1 = (s1 << esd_pkg::FRAC_BITS) / s2;
            q2 = int_sqrt(ratio_2f((s1 - s0) * (s1 - s0), s0 * s0 + s1 * s1));
            st = (q1 * q2) >> esd_pkg::FRAC_BITS;
            diff = longint'(un) - longint'(st);
            d.sph    = diff[esd_pkg::SPH_W-1:0];
            d.uns    = emit_uns ? un[esd_pkg::UNS_W-1:0] : '0;
            d.str    = emit_str ? st[esd_pkg::UNS_W-1:0] : '0;
            d.status = esd_pkg::STATUS_OK;
         end
         pending.insert(pending.size(), d);
      endfunction

      function void check_result(descriptor_type got);
         descriptor_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected sph %0d uns %0d str %0d st %0d, ",
                         "got sph %0d uns %0d str %0d st %0d"},
                        want.sph, want.uns, want.str, want.status,
                        got.sph, got.uns, got.str, got.status);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [31:0] req_eig_first = 0, req_eig_second = 0, req_eig_third = 0;
   logic rsp_strobe;
   logic signed [esd_pkg::SPH_W-1:0] rsp_sphericality;
   logic [esd_pkg::UNS_W-1:0] rsp_unstructureness, rsp_structureness;
   logic [esd_pkg::STATUS_W-1:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [esd_pkg::CSR_IDX_W-1:0] csr_index = esd_pkg::CSR_EMIT_UNS;
   logic csr_wdata = 0;

   descriptor_scoreboard board = new();
   int idle_cycles;
   bit quiet_tail;
   bit accepted;

   always #10 clock = ~clock;

   eigen_sphericality_descriptor uut (.*);

   // Check results and watch for a stuck run
   always @(posedge clock) begin
      accepted = 0;
      if (!reset && rsp_strobe) begin
         board.check_result({rsp_sphericality, rsp_unstructureness, rsp_structureness,
                             rsp_status});
         accepted = 1;
      end
      if (!reset && start && !busy) accepted = 1;
      if (!reset && csr_valid && csr_ready) accepted = 1;
      idle_cycles = accepted ? 0 : idle_cycles + 1;
      if (idle_cycles >= 5000) begin
         $display("eigen_sphericality_descriptor verification failed");
         $finish;
      end
   end

   task automatic write_csr(logic [esd_pkg::CSR_IDX_W-1:0] idx, logic val);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == esd_pkg::CSR_EMIT_UNS) board.emit_uns = val; else board.emit_str = val;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_triple(logic signed [31:0] e0, logic signed [31:0] e1,
                              logic signed [31:0] e2);
      int gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         start <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1; req_eig_first <= e0; req_eig_second <= e1; req_eig_third <= e2;
      do @(posedge clock); while (busy);
      board.note_triple(e0, e1, e2);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (esd_pkg::LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 255);
         2: return $urandom_range(0, 65535);
         3: return $urandom & 32'h7fffffff;
         4: return 32'h7fffffff - $urandom_range(0, 1000);
         default: return $urandom_range(0, 3) == 0 ? 0 : ($urandom >> $urandom_range(0, 31));
      endcase
   endfunction

   task automatic random_phase(int count);
      logic signed [31:0] v0, v1, v2;
      for (int i = 0; i < count; i++) begin
         v0 = rand_value(); v1 = rand_value(); v2 = rand_value();
         // Mostly nonnegative triples so the full computation runs
         if ($urandom_range(0, 9) != 0) begin
            v0[31] = 0; v1[31] = 0; v2[31] = 0;
         end
         send_triple(v0, v1, v2);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, undefined and degenerate cases, orderings
      send_triple(1, 2, 3);
      send_triple(3, 1, 2);
      send_triple(2, 3, 1);
      send_triple(0, 0, 0);
      send_triple(-1, 5, 7);
      send_triple(-5, -3, -1);
      send_triple(0, 0, 9);
      send_triple(32'sh80000000, 32'sh7fffffff, 1);
      send_triple(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_triple(0, 32'sh7fffffff, 32'sh7fffffff);
      send_triple(0, 1, 32'sh7fffffff);
      send_triple(1, 1, 1);
      send_triple(0, 5, 5);
      send_triple(4, 4, 4);
      send_triple(32'sh7ffffffe, 32'sh7fffffff, 0);
      drain();

      write_csr(esd_pkg::CSR_EMIT_UNS, 1);
      write_csr(esd_pkg::CSR_EMIT_STR, 1);
      send_triple(1, 2, 3);
      send_triple(0, 1, 32'sh7fffffff);
      send_triple(0, 32'sh7fffffff, 32'sh7fffffff);
      send_triple(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_triple(3, 4, 100);
      send_triple(32'sh80000000, 32'sh80000000, 32'sh80000000);
      random_phase(500);
      drain();

      write_csr(esd_pkg::CSR_EMIT_UNS, 1);
      write_csr(esd_pkg::CSR_EMIT_STR, 0);
      random_phase(400);
      drain();

      write_csr(esd_pkg::CSR_EMIT_UNS, 0);
      write_csr(esd_pkg::CSR_EMIT_STR, 1);
      random_phase(400);
      drain();

      write_csr(esd_pkg::CSR_EMIT_UNS, 1);
      write_csr(esd_pkg::CSR_EMIT_STR, 1);
      quiet_tail = 1;
      random_phase(400);
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("eigen_sphericality_descriptor verification clean");
      end else begin
         $display("eigen_sphericality_descriptor verification failed");
      end
      $finish;
   end
endmodule

// ===== eigen_sphericality_descriptor.f =====
+incdir+hdl
hdl/esd_pkg.sv
hdl/esd_front.sv
hdl/esd_cell.sv
hdl/eigen_sphericality_descriptor.sv
test/testbench.sv
